// ===== hw/rtl/cumulative_angle_histogram_core_macros.svh =====
// Assertion macros for the cumulative angle histogram core.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef CUMULATIVE_ANGLE_HISTOGRAM_CORE_MACROS_SVH
`define CUMULATIVE_ANGLE_HISTOGRAM_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CAH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CAH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cah_pkg.sv =====
// Shared types and constants of the cumulative angle histogram core.
// Holds the request and result structs and the squared cosine threshold table.
package cah_pkg;

	localparam int COMP_BITS = 16;
	localparam int FRAC_BITS = 16;
	localparam int QSQ_BITS  = 33;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                        cmd;
		logic signed [COMP_BITS-1:0] dir_x;
		logic signed [COMP_BITS-1:0] dir_y;
		logic signed [COMP_BITS-1:0] dir_z;
		logic [7:0]                  bin_index;
	} cah_in_t;

	typedef struct packed {
		logic [31:0]        bin_count;
		logic [31:0]        sample_total;
		logic [FRAC_BITS:0] bin_fraction;
		logic               index_error;
	} cah_out_t;

	typedef logic [QSQ_BITS-1:0] cos_sq_tab_t [0:90];

	localparam logic [63:0] ONE_Q30 = 64'd1073741824;
	localparam logic [63:0] PI_Q30  = 64'd3373259426;

	// Truncating long division by shift and subtract, used while the table is built.
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Squared cosine of 0..90 degrees in Q1.32, built by a truncating Taylor series.
	function automatic cos_sq_tab_t build_cos_sq();
		cos_sq_tab_t        tab;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        c;
		logic [63:0]        den;
		logic signed [63:0] sum;
		for (int d = 0; d <= 90; d++) begin
			x = udiv64(64'(d) * PI_Q30 + 64'd90, 64'd180);
			x2 = (x * x) >> 30;
			term = ONE_Q30;
			sum = $signed(ONE_Q30);
			for (int k = 1; k <= 12; k++) begin
				den = (64'(2 * k) - 64'd1) * 64'(2 * k);
				term = udiv64((term * x2) >> 30, den);
				if ((k & 1) == 1) begin
					sum = sum - $signed(term);
				end else begin
					sum = sum + $signed(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > $signed(ONE_Q30)) begin
				sum = $signed(ONE_Q30);
			end
			if (d == 90) begin
				sum = 0;
			end
			c = $unsigned(sum);
			tab[d] = QSQ_BITS'((c * c + 64'd134217728) >> 28);
		end
		return tab;
	endfunction

	localparam cos_sq_tab_t COS_SQ = build_cos_sq();

endpackage

// ===== hw/rtl/cumulative_angle_histogram_core.sv =====
// Top level of the cumulative angle histogram core; uses cah_pkg, cah_frac_div and the
// assertion macros. An add request carries a direction vector and raises the sample
// total; every bin l whose angle bound l+1 degrees exceeds the vector's angle from the
// up axis is raised by one. A query request returns one bin's count, the total and
// their ratio in Q1.16. An add runs a binary search over the squared cosine table
// (one multiply and one compare per step), then raises the bins one after another and
// writes the last count back, since every raised bin goes through the single
// read-modify-write port of the count memory (up to NUM_BINS bins for vectors near the
// up axis). A zero vector raises only the sample total. A query runs the bit-serial
// divider unless the total is zero, and a bad index skips it. The count memory needs no
// clearing pass: one valid bit per bin, cleared at reset, makes an unwritten bin read as
// zero. Only one request is worked on at a time; a finished result waits in the output
// register and the next request can be taken meanwhile.
module cumulative_angle_histogram_core #(
	parameter int NUM_BINS   = 180,
	parameter int COUNT_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cah_pkg::cah_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output cah_pkg::cah_out_t out_data
);
	import cah_pkg::*;

	localparam int AW = (NUM_BINS > 2) ? $clog2(NUM_BINS) : 1;
	localparam int DW = $clog2(NUM_BINS + 2);
	localparam int EW = (DW > 9) ? DW : 9;
	localparam int SQ_BITS = 2 * COMP_BITS - 1;
	localparam int LEN_BITS = SQ_BITS + 1;
	localparam int PROD_BITS = QSQ_BITS + LEN_BITS;
	localparam int CMP_BITS = PROD_BITS + 1;
	localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SQ    = 4'd1;
	localparam logic [3:0] S_LEN   = 4'd2;
	localparam logic [3:0] S_MUL   = 4'd3;
	localparam logic [3:0] S_CMP   = 4'd4;
	localparam logic [3:0] S_SWEEP = 4'd5;
	localparam logic [3:0] S_QDAT  = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_QOUT  = 4'd8;

	logic [3:0] state_q;

	// Sample registers of the add path.
	logic signed [COMP_BITS-1:0] x_q;
	logic signed [COMP_BITS-1:0] y_q;
	logic signed [COMP_BITS-1:0] z_q;
	logic [COMP_BITS:0]          ax;
	logic [COMP_BITS:0]          ay;
	logic [COMP_BITS:0]          az;
	logic [SQ_BITS-1:0]          xx_q;
	logic [SQ_BITS-1:0]          yy_q;
	logic [SQ_BITS-1:0]          zz_q;
	logic [LEN_BITS-1:0]         len2_q;
	logic                        y_pos_q;
	logic                        y_neg_q;

	// Binary search for the smallest degree bound that the vector lies under.
	logic [DW-1:0]        lo_q;
	logic [DW-1:0]        hi_q;
	logic [DW:0]          mid_sum;
	logic [DW-1:0]        mid;
	logic [EW-1:0]        mid_e;
	logic                 mid_le90;
	logic                 mid_big;
	logic [6:0]           tab_idx;
	logic [QSQ_BITS-1:0]  q_sel;
	logic [PROD_BITS-1:0] prod_s1;
	logic [DW-1:0]        mid_s1;
	logic                 le90_s1;
	logic                 big_s1;
	logic                 qzero_s1;
	logic [CMP_BITS-1:0]  s_wide;
	logic [CMP_BITS-1:0]  r_wide;
	logic                 below;

	// Count memory and its read-modify-write pipe.
	logic [COUNT_BITS-1:0] mem [0:NUM_BINS-1];
	logic [NUM_BINS-1:0]   vld_q;
	logic [AW-1:0]         raddr;
	logic [COUNT_BITS-1:0] rd_data_s1;
	logic                  rd_vld_s1;
	logic [AW-1:0]         addr_q;
	logic                  issue_q;
	logic                  rdv_s1;
	logic [AW-1:0]         wa_s1;
	logic [COUNT_BITS-1:0] cur_cnt;
	logic [COUNT_BITS-1:0] inc_cnt;

	logic [COUNT_BITS-1:0] total_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [FRAC_BITS:0]    frac_q;
	logic                  err_q;
	logic                  div_start;
	logic                  div_done;
	logic [FRAC_BITS:0]    div_quot;
	logic                  in_fire;
	logic                  out_load;

	logic     out_valid_q;
	cah_out_t out_q;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire = in_valid && in_ready;
	assign out_load = (state_q == S_QOUT) && (!out_valid_q || out_ready);

	// Magnitudes of the components; the most negative value still fits one bit wider.
	always_comb begin
		ax = x_q[COMP_BITS-1] ? (COMP_BITS+1)'(-{x_q[COMP_BITS-1], x_q}) : {1'b0, x_q};
		ay = y_q[COMP_BITS-1] ? (COMP_BITS+1)'(-{y_q[COMP_BITS-1], y_q}) : {1'b0, y_q};
		az = z_q[COMP_BITS-1] ? (COMP_BITS+1)'(-{z_q[COMP_BITS-1], z_q}) : {1'b0, z_q};
	end

	// Bounds above 90 degrees mirror the table; bounds above 180 always pass.
	always_comb begin
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
		mid = mid_sum[DW:1];
		mid_e = EW'(mid);
		mid_le90 = mid_e <= EW'(90);
		mid_big = mid_e > EW'(180);
		if (mid_le90) begin
			tab_idx = mid_e[6:0];
		end else if (mid_big) begin
			tab_idx = 7'd0;
		end else begin
			tab_idx = 7'(EW'(180) - mid_e);
		end
		q_sel = COS_SQ[tab_idx];
	end

	// The angle test y > cos(d) * len, squared: y^2 * 2^32 against q * len^2.
	always_comb begin
		s_wide = CMP_BITS'({yy_q, 32'b0});
		r_wide = CMP_BITS'(prod_s1);
		if (big_s1) begin
			below = 1'b1;
		end else if (le90_s1) begin
			below = y_pos_q && (qzero_s1 || (s_wide > r_wide));
		end else begin
			below = !y_neg_q || (s_wide < r_wide);
		end
	end

	always_comb begin
		if (state_q == S_SWEEP) begin
			raddr = addr_q;
		end else begin
			raddr = AW'(in_data.bin_index);
		end
		cur_cnt = rd_vld_s1 ? rd_data_s1 : '0;
		inc_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (rdv_s1) begin
			mem[wa_s1] <= inc_cnt;
		end
		rd_data_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (rdv_s1) begin
				vld_q[wa_s1] <= 1'b1;
			end
			rd_vld_s1 <= vld_q[raddr];
		end
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			issue_q <= 1'b0;
			rdv_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_s1 <= (state_q == S_SWEEP) && issue_q;
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (in_data.cmd == CMD_ADD) begin
							if (total_q != '1) begin
								total_q <= total_q + 1'b1;
							end
							state_q <= S_SQ;
						end else if (32'(in_data.bin_index) >= 32'(NUM_BINS)) begin
							state_q <= S_QOUT;
						end else begin
							state_q <= S_QDAT;
						end
					end
				end
				S_SQ: begin
					state_q <= S_LEN;
				end
				S_LEN: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (len2_q == '0) begin
						state_q <= S_IDLE;
					end else if (lo_q == hi_q) begin
						if (lo_q <= DW'(NUM_BINS)) begin
							issue_q <= 1'b1;
							state_q <= S_SWEEP;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_MUL;
				end
				S_SWEEP: begin
					if (issue_q && (addr_q == LAST_BIN)) begin
						issue_q <= 1'b0;
					end
					if (!issue_q && rdv_s1) begin
						state_q <= S_IDLE;
					end
				end
				S_QDAT: begin
					state_q <= (total_q == '0) ? S_QOUT : S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_QOUT;
					end
				end
				S_QOUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; no reset needed, the sequencer qualifies them.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q <= in_data.dir_x;
			y_q <= in_data.dir_y;
			z_q <= in_data.dir_z;
			err_q <= (in_data.cmd == CMD_QUERY) &&
				(32'(in_data.bin_index) >= 32'(NUM_BINS));
		end
		if (state_q == S_SQ) begin
			xx_q <= SQ_BITS'(ax * ax);
			yy_q <= SQ_BITS'(ay * ay);
			zz_q <= SQ_BITS'(az * az);
			y_pos_q <= !y_q[COMP_BITS-1] && (y_q != '0);
			y_neg_q <= y_q[COMP_BITS-1];
		end
		if (state_q == S_LEN) begin
			len2_q <= LEN_BITS'({1'b0, xx_q}) + LEN_BITS'({1'b0, yy_q}) +
				LEN_BITS'({1'b0, zz_q});
			lo_q <= DW'(1);
			hi_q <= DW'(NUM_BINS + 1);
		end
		if (state_q == S_MUL) begin
			prod_s1 <= PROD_BITS'(q_sel) * PROD_BITS'(len2_q);
			mid_s1 <= mid;
			le90_s1 <= mid_le90;
			big_s1 <= mid_big;
			qzero_s1 <= (q_sel == '0);
			addr_q <= AW'(lo_q - 1'b1);
		end
		if (state_q == S_CMP) begin
			if (below) begin
				hi_q <= mid_s1;
			end else begin
				lo_q <= mid_s1 + 1'b1;
			end
		end
		// The write address is the read address registered, so it lines up with the read data.
		wa_s1 <= addr_q;
		if ((state_q == S_SWEEP) && issue_q && (addr_q != LAST_BIN)) begin
			addr_q <= addr_q + 1'b1;
		end
		if (state_q == S_QDAT) begin
			cnt_q <= cur_cnt;
			frac_q <= '0;
		end
		if ((state_q == S_DIV) && div_done) begin
			frac_q <= div_quot;
		end
		if (out_load) begin
			if (err_q) begin
				out_q <= '{bin_count: '0, sample_total: '0, bin_fraction: '0,
					index_error: 1'b1};
			end else begin
				out_q.bin_count <= 32'(cnt_q);
				out_q.sample_total <= 32'(total_q);
				out_q.bin_fraction <= frac_q;
				out_q.index_error <= 1'b0;
			end
		end
	end

	assign div_start = (state_q == S_QDAT) && (total_q != '0);

	cah_frac_div #(
		.CW(COUNT_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(cur_cnt),
		.den(total_q),
		.done(div_done),
		.quot(div_quot)
	);

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`include "cumulative_angle_histogram_core_macros.svh"

	`CAH_ASSERT_NOW(a_idle_no_rmw, in_ready, !rdv_s1, "request taken while a bin update is in flight")
	`CAH_ASSERT_NOW(a_err_zero, out_valid && out_data.index_error, out_data.bin_count == 0 && out_data.sample_total == 0 && out_data.bin_fraction == 0, "error result with nonzero fields")
	`CAH_ASSERT_NOW(a_frac_range, out_valid, out_data.bin_fraction <= 17'd65536, "fraction above one")
	`CAH_ASSERT_NEXT(a_result_loaded, out_load, out_valid_q && (state_q == S_IDLE), "query result not presented")

endmodule

// ===== hw/rtl/cah_frac_div.sv =====
// Restoring divider for the bin fraction, one quotient bit per cycle.
// Uses cah_pkg for the fraction width; expects num <= den and den != 0.
module cah_frac_div #(
	parameter int CW = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [CW-1:0]               num,
	input  logic [CW-1:0]               den,
	output logic                        done,
	output logic [cah_pkg::FRAC_BITS:0] quot
);
	import cah_pkg::*;

	localparam int SW = $clog2(FRAC_BITS + 2);

	logic [CW:0]        rem_q;
	logic [CW-1:0]      den_q;
	logic [FRAC_BITS:0] quot_q;
	logic [SW-1:0]      left_q;
	logic               first_q;
	logic               busy_q;
	logic               done_q;
	logic [CW:0]        trial;
	logic               bit_ok;

	// The first step compares the numerator unshifted: it yields the integer bit.
	always_comb begin
		trial = first_q ? rem_q : {rem_q[CW-1:0], 1'b0};
		bit_ok = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
			first_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				first_q <= 1'b1;
				left_q <= SW'(FRAC_BITS + 1);
			end else if (busy_q) begin
				first_q <= 1'b0;
				left_q <= left_q - 1'b1;
				if (left_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= bit_ok ? trial - {1'b0, den_q} : trial;
			quot_q <= {quot_q[FRAC_BITS-1:0], bit_ok};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
